// ===== rtl/kare_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kare_pkg
// Shared codes, types and sizes of the key auto-repeat engine.
// ----------------------------------------------------------------------------
package kare_pkg;

  // Largest supported key count and the address width that covers it
  localparam int KARE_MAX_KEYS = 64;
  localparam int KARE_NUM_KEYS = 64;
  localparam int MEM_AW        = $clog2(KARE_MAX_KEYS);

  // Input operation codes (code 3 is unused and dropped)
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Event kinds
  localparam logic [1:0] EV_DOWN   = 2'd0;
  localparam logic [1:0] EV_UP     = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INITIAL_DELAY = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_REPEAT_ENABLE = 2'd2;

  // Per-key entry as stored in the state memory
  typedef struct packed {
    logic        held;
    logic [31:0] since_time;
    logic        repeating;
    logic        resolved;
  } entry_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] initial_delay;
    logic [15:0] repeat_period;
    logic        repeat_enable;
  } cfg_t;

  // Request from the controller to the state memory
  typedef struct packed {
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    entry_t            wr_data;
    logic              clr_en;
    logic [MEM_AW-1:0] clr_addr;
  } mem_req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS,
    ST_RELEASE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

endpackage : kare_pkg
`default_nettype wire

// ===== rtl/kare_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kare_req_if
// Input channel: press, release and tick transactions.
// ----------------------------------------------------------------------------
interface kare_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  key;
  logic [31:0] now;

  modport source (output valid, output op, output key, output now, input ready);
  modport sink   (input valid, input op, input key, input now, output ready);
endinterface : kare_req_if
`default_nettype wire

// ===== rtl/kare_evt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kare_evt_if
// Output channel: key down, key up and repeat event transactions.
// ----------------------------------------------------------------------------
interface kare_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] event_key;
  logic       last;

  modport source (output valid, output event_kind, output event_key, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input event_key, input last,
                  output ready);
endinterface : kare_evt_if
`default_nettype wire

// ===== rtl/kare_entry_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kare_entry_mem
// Per-key state memory: one write port, one registered read port, and a
// valid bit per entry so that reset and key release read back as all zero.
// ----------------------------------------------------------------------------
module kare_entry_mem
  import kare_pkg::*;
#(
  parameter int NUM_KEYS = KARE_NUM_KEYS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  entry_t              mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld;
  entry_t              rd_q;
  logic                rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr[AW-1:0]];
    end
  end

  // Track written entries; clear on reset and on release
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.clr_en) begin
        vld[req.clr_addr[AW-1:0]] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_vld_q <= vld[req.rd_addr[AW-1:0]];
      end
    end
  end

  // An entry never written since reset or release reads as zero
  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule : kare_entry_mem
`default_nettype wire

// ===== rtl/kare_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kare_ctrl
// Transaction sequencer: handles press and release, sweeps the key memory
// on a tick, and orders events through a pending slot and an output register
// so that the final event of a transaction carries the last flag.
// ----------------------------------------------------------------------------
module kare_ctrl
  import kare_pkg::*;
#(
  parameter int NUM_KEYS = KARE_NUM_KEYS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  kare_req_if.sink      req,
  kare_evt_if.source    evt,
  output mem_req_t      mreq,
  input  wire entry_t   rd_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_KEYS - 1);

  state_t        state, state_next;
  logic [AW-1:0] key_q;
  logic [31:0]   now_q;
  logic [AW-1:0] eidx;
  logic          pend_v;
  logic [AW-1:0] pend_key;
  logic          ov;
  logic [1:0]    out_kind;
  logic [7:0]    out_key;
  logic          out_last;

  logic          in_acc;
  logic          key_ok;
  logic          slot_free;
  logic [15:0]   delay;
  logic [32:0]   deadline;
  logic          due;
  logic          advance;

  logic          out_ld;
  logic [1:0]    out_kind_d;
  logic [7:0]    out_key_d;
  logic          out_last_d;
  logic          pend_set;
  logic          pend_clr;
  logic          eidx_inc;

  // Input handshake and shared conditions
  assign req.ready = (state == ST_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign key_ok    = (req.key < 8'(NUM_KEYS));
  assign slot_free = !ov || evt.ready;

  // Repeat deadline of the entry under sweep, full 33-bit precision
  assign delay    = rd_data.repeating ? cfg.repeat_period : cfg.initial_delay;
  assign deadline = {1'b0, rd_data.since_time} + {17'd0, delay};
  assign due      = rd_data.held && rd_data.resolved && ({1'b0, now_q} >= deadline);
  // Hold the sweep only when a new event needs both slots and both are full
  assign advance  = !due || !pend_v || slot_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (req.op == OP_PRESS && key_ok) begin
            state_next = ST_PRESS;
          end else if (req.op == OP_RELEASE && key_ok) begin
            state_next = ST_RELEASE;
          end else if (req.op == OP_TICK && cfg.repeat_enable) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_PRESS, ST_RELEASE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (advance && eidx == LAST_IDX) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory requests, event loads and counter controls
  always_comb begin
    mreq       = '0;
    out_ld     = 1'b0;
    out_kind_d = EV_DOWN;
    out_key_d  = 8'(key_q);
    out_last_d = 1'b1;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    eidx_inc   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (req.op == OP_PRESS && key_ok) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = MEM_AW'(req.key);
          end else if (req.op == OP_RELEASE && key_ok) begin
            mreq.clr_en   = 1'b1;
            mreq.clr_addr = MEM_AW'(req.key);
          end else if (req.op == OP_TICK && cfg.repeat_enable) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = '0;
          end
        end
      end
      ST_PRESS: begin
        // Record the press time only when the key was idle
        if (slot_free) begin
          out_ld     = 1'b1;
          out_kind_d = EV_DOWN;
          if (!rd_data.held) begin
            mreq.wr_en      = 1'b1;
            mreq.wr_addr    = MEM_AW'(key_q);
            mreq.wr_data    = '{held: 1'b1, since_time: now_q,
                                repeating: 1'b0, resolved: 1'b0};
          end
        end
      end
      ST_RELEASE: begin
        if (slot_free) begin
          out_ld     = 1'b1;
          out_kind_d = EV_UP;
        end
      end
      ST_SWEEP: begin
        if (advance) begin
          // Write back a held entry: resolve it, or advance its time on a repeat
          mreq.wr_en   = rd_data.held;
          mreq.wr_addr = MEM_AW'(eidx);
          mreq.wr_data = rd_data;
          if (!rd_data.resolved) begin
            mreq.wr_data.resolved = 1'b1;
          end else if (due) begin
            mreq.wr_data.since_time = deadline[31:0];
            mreq.wr_data.repeating  = 1'b1;
          end
          // Retire the older pending event when a new one arrives
          if (due) begin
            pend_set = 1'b1;
            if (pend_v) begin
              out_ld     = 1'b1;
              out_kind_d = EV_REPEAT;
              out_key_d  = 8'(pend_key);
              out_last_d = 1'b0;
            end
          end
          // Fetch the next entry
          if (eidx != LAST_IDX) begin
            eidx_inc     = 1'b1;
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = MEM_AW'(eidx + AW'(1));
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v && slot_free) begin
          out_ld     = 1'b1;
          out_kind_d = EV_REPEAT;
          out_key_d  = 8'(pend_key);
          out_last_d = 1'b1;
          pend_clr   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_v <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state <= state_next;
      if (pend_set) begin
        pend_v <= 1'b1;
      end else if (pend_clr) begin
        pend_v <= 1'b0;
      end
      if (out_ld) begin
        ov <= 1'b1;
      end else if (evt.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Latched transaction fields, sweep index and event payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_q <= req.key[AW-1:0];
      now_q <= req.now;
      eidx  <= '0;
    end else if (eidx_inc) begin
      eidx <= eidx + AW'(1);
    end
    if (pend_set) begin
      pend_key <= eidx;
    end
    if (out_ld) begin
      out_kind <= out_kind_d;
      out_key  <= out_key_d;
      out_last <= out_last_d;
    end
  end

  assign evt.valid      = ov;
  assign evt.event_kind = out_kind;
  assign evt.event_key  = out_key;
  assign evt.last       = out_last;

endmodule : kare_ctrl
`default_nettype wire

// ===== rtl/key_auto_repeat_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_auto_repeat_engine
// Per-key typematic auto-repeat: key down/up events on press and release,
// repeat events from a sweep of all keys on each time tick while repeat is enabled.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid / ready  op, key, now
//  evt      out  valid / ready  event_kind, event_key, last
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  A tick sweeps the key memory one entry per cycle unless the sweep is held,
//  a rate set by the single read port of that memory. A stalled event output
//  holds the sweep only when a new event finds both the pending slot and the
//  output register full. Synchronous reset clears all keys at once through
//  per-entry valid bits.
// ----------------------------------------------------------------------------
module key_auto_repeat_engine
  import kare_pkg::*;
#(
  parameter int NUM_KEYS = KARE_NUM_KEYS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  kare_req_if.sink         req,
  kare_evt_if.source       evt
);

  cfg_t     cfg;
  mem_req_t mreq;
  entry_t   rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay <= 16'd500;
      cfg.repeat_period <= 16'd100;
      cfg.repeat_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_DELAY: cfg.initial_delay <= cfg_data;
        CFG_REPEAT_PERIOD: cfg.repeat_period <= cfg_data;
        CFG_REPEAT_ENABLE: cfg.repeat_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kare_ctrl #(
    .NUM_KEYS (NUM_KEYS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .evt     (evt),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  kare_entry_mem #(
    .NUM_KEYS (NUM_KEYS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (rd_data)
  );

endmodule : key_auto_repeat_engine
`default_nettype wire

// ===== tb/key_auto_repeat_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_auto_repeat_engine_test
// Self-checking bench for the typematic repeat engine. A short table of
// press, release, tick and unused-op transactions covers the edge cases:
// out-of-range keys, double press, release of an idle key, the exact
// deadline and a deadline past 32 bits. Random phases follow under several
// register settings, including zero and full-scale delays and repeat off.
// A shadow copy of the per-key state predicts every event. Both channels
// stall at random, and once the event side holds off long enough to back
// the engine up into its input.
// ----------------------------------------------------------------------------
module key_auto_repeat_engine_test;
  import kare_pkg::*;

  localparam int          NUM_KEYS     = KARE_NUM_KEYS;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          DRAIN_CYCLES = NUM_KEYS + 16;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          MAX_PRINTS   = 50;
  localparam longint      TIMEOUT_NS   = 64'd10_000_000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key;
    logic       last;
  } key_event_t;

  // How a table row is checked
  typedef enum logic [1:0] {
    USE_MODEL,
    EXPECT_NONE,
    EXPECT_ONE
  } row_check_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  key;
    logic [31:0] now;
    row_check_t  check;
    logic [1:0]  kind;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  kare_req_if req_ch ();
  kare_evt_if evt_ch ();

  key_auto_repeat_engine #(
    .NUM_KEYS (NUM_KEYS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .evt       (evt_ch)
  );

  // Shadow key state and register copies
  bit          shadow_held      [NUM_KEYS];
  logic [31:0] shadow_since     [NUM_KEYS];
  bit          shadow_repeating [NUM_KEYS];
  bit          shadow_resolved  [NUM_KEYS];
  logic [15:0] shadow_first_delay;
  logic [15:0] shadow_period;
  bit          shadow_enable;

  key_event_t  item_events[$];
  key_event_t  pending_events[$];
  stim_row_t   directed_rows[$];

  int          error_count;
  bit          no_gaps;
  bit          hold_off;
  logic [31:0] cur_time;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Compute the events one transaction causes, advancing the shadow state
  function automatic void predict_events(input logic [1:0] op, input logic [7:0] key,
                                         input logic [31:0] now);
    key_event_t  ev;
    logic [15:0] delay;
    logic [32:0] deadline;
    item_events.delete();
    case (op)
      OP_PRESS: begin
        if (key < NUM_KEYS) begin
          if (!shadow_held[key]) begin
            shadow_held[key]      = 1'b1;
            shadow_since[key]     = now;
            shadow_repeating[key] = 1'b0;
            shadow_resolved[key]  = 1'b0;
          end
          ev.kind = EV_DOWN;
          ev.key  = key;
          ev.last = 1'b0;
          item_events.push_back(ev);
        end
      end
      OP_RELEASE: begin
        if (key < NUM_KEYS) begin
          shadow_held[key]      = 1'b0;
          shadow_since[key]     = '0;
          shadow_repeating[key] = 1'b0;
          shadow_resolved[key]  = 1'b0;
          ev.kind = EV_UP;
          ev.key  = key;
          ev.last = 1'b0;
          item_events.push_back(ev);
        end
      end
      OP_TICK: begin
        if (shadow_enable) begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (shadow_held[i]) begin
              if (!shadow_resolved[i]) begin
                shadow_resolved[i] = 1'b1;
              end else begin
                delay    = shadow_repeating[i] ? shadow_period : shadow_first_delay;
                deadline = {1'b0, shadow_since[i]} + {17'd0, delay};
                if ({1'b0, now} >= deadline) begin
                  shadow_since[i]     = deadline[31:0];
                  shadow_repeating[i] = 1'b1;
                  ev.kind = EV_REPEAT;
                  ev.key  = i[7:0];
                  ev.last = 1'b0;
                  item_events.push_back(ev);
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    // Flag the final event of this transaction
    if (item_events.size() > 0) begin
      ev = item_events.pop_back();
      ev.last = 1'b1;
      item_events.push_back(ev);
    end
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [7:0] key,
                                  input logic [31:0] now, input row_check_t check,
                                  input logic [1:0] kind);
    stim_row_t row;
    row.op    = op;
    row.key   = key;
    row.now   = now;
    row.check = check;
    row.kind  = kind;
    directed_rows.push_back(row);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, NUM_KEYS - 1));
    return 8'($urandom_range(0, 15));
  endfunction

  // Offer one transaction, then record its expected events on acceptance
  task automatic send_item(input logic [1:0] op, input logic [7:0] key,
                           input logic [31:0] now, input row_check_t check,
                           input logic [1:0] kind);
    key_event_t ev;
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    req_ch.now   <= now;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predict_events(op, key, now);
    if (check == USE_MODEL) begin
      foreach (item_events[i]) pending_events.push_back(item_events[i]);
    end else if (check == EXPECT_ONE) begin
      ev.kind = kind;
      ev.key  = key;
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
  endtask

  task automatic pause_sender();
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid, drain all events, then let a silent sweep finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INITIAL_DELAY: shadow_first_delay = value;
      CFG_REPEAT_PERIOD: shadow_period      = value;
      CFG_REPEAT_ENABLE: shadow_enable      = value[0];
      default: begin
      end
    endcase
  endtask

  // Random phase: mostly well-formed press/release/tick traffic, some noise
  task automatic run_phase(input int count, input logic [31:0] base,
                           input int unsigned step_max, input int hold_at);
    int unsigned r;
    logic [1:0]  op;
    logic [7:0]  key;
    logic [31:0] now;
    cur_time = base;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      // Back up the engine: event side holds off, sender keeps pressing
      if (n == hold_at) begin
        hold_off = 1'b1;
        for (int k = 0; k < 24; k++) begin
          cur_time += $urandom_range(0, 3);
          send_item(OP_PRESS, pick_key(), cur_time, USE_MODEL, EV_DOWN);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 36) begin
        op = OP_PRESS;
        key = pick_key();
        cur_time += $urandom_range(0, step_max / 4);
        now = cur_time;
      end else if (r < 56) begin
        op = OP_RELEASE;
        key = pick_key();
        cur_time += $urandom_range(0, step_max / 4);
        now = cur_time;
      end else if (r < 90) begin
        op = OP_TICK;
        key = 8'($urandom_range(0, 255));
        cur_time += $urandom_range(0, step_max);
        now = cur_time;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_UNUSED;
          1:       op = OP_PRESS;
          default: op = OP_RELEASE;
        endcase
        key = (op == OP_UNUSED) ? 8'($urandom_range(0, 255))
                                : 8'($urandom_range(NUM_KEYS, 255));
        now = $urandom;
      end
      send_item(op, key, now, USE_MODEL, EV_DOWN);
      pause_sender();
    end
    no_gaps = 1'b0;
  endtask

  // Check each accepted event against the oldest expectation
  always @(posedge clk) begin : evt_monitor
    key_event_t want;
    if (rst === 1'b0 && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind=%0d key=%0d",
                                  evt_ch.event_kind, evt_ch.event_key));
      end else begin
        want = pending_events.pop_front();
        if (evt_ch.event_kind !== want.kind)
          report_mismatch($sformatf("event_kind %0d, want %0d (key %0d)",
                                    evt_ch.event_kind, want.kind, want.key));
        if (evt_ch.event_key !== want.key)
          report_mismatch($sformatf("event_key %0d, want %0d",
                                    evt_ch.event_key, want.key));
        if (evt_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (key %0d)",
                                    evt_ch.last, want.last, want.key));
      end
    end
  end

  // Event side: random back-pressure plus one long hold-off
  initial begin : evt_sink
    int unsigned n;
    evt_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off) begin
        evt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      n = gap_len();
      if (n > 0) begin
        evt_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      evt_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    error_count = 0;
    no_gaps     = 1'b0;
    hold_off    = 1'b0;
    cur_time    = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      shadow_held[i]      = 1'b0;
      shadow_since[i]     = '0;
      shadow_repeating[i] = 1'b0;
      shadow_resolved[i]  = 1'b0;
    end
    shadow_first_delay = 16'd500;
    shadow_period      = 16'd100;
    shadow_enable      = 1'b1;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op    <= '0;
    req_ch.key   <= '0;
    req_ch.now   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, under the reset register values
    add_row(OP_PRESS,   8'd0,   32'd1000,       EXPECT_ONE,  EV_DOWN);
    add_row(OP_PRESS,   8'd63,  32'd1000,       EXPECT_ONE,  EV_DOWN);
    add_row(OP_PRESS,   8'd64,  32'd1000,       EXPECT_NONE, EV_DOWN);
    add_row(OP_PRESS,   8'd255, 32'd1000,       EXPECT_NONE, EV_DOWN);
    add_row(OP_RELEASE, 8'd200, 32'd1000,       EXPECT_NONE, EV_UP);
    add_row(OP_UNUSED,  8'd5,   32'd1000,       EXPECT_NONE, EV_DOWN);
    add_row(OP_TICK,    8'd0,   32'd1000,       USE_MODEL,   EV_REPEAT);
    add_row(OP_TICK,    8'd255, 32'd1499,       USE_MODEL,   EV_REPEAT);
    add_row(OP_TICK,    8'd0,   32'd1500,       USE_MODEL,   EV_REPEAT);
    add_row(OP_TICK,    8'd0,   32'd1600,       USE_MODEL,   EV_REPEAT);
    add_row(OP_PRESS,   8'd0,   32'd1650,       EXPECT_ONE,  EV_DOWN);
    add_row(OP_TICK,    8'd0,   32'd1700,       USE_MODEL,   EV_REPEAT);
    add_row(OP_RELEASE, 8'd0,   32'd1750,       EXPECT_ONE,  EV_UP);
    add_row(OP_RELEASE, 8'd0,   32'd1760,       EXPECT_ONE,  EV_UP);
    add_row(OP_TICK,    8'd0,   32'd5000,       USE_MODEL,   EV_REPEAT);
    add_row(OP_PRESS,   8'd10,  32'hFFFF_FF00,  EXPECT_ONE,  EV_DOWN);
    add_row(OP_TICK,    8'd0,   32'hFFFF_FFFF,  USE_MODEL,   EV_REPEAT);
    add_row(OP_TICK,    8'd0,   32'hFFFF_FFFF,  USE_MODEL,   EV_REPEAT);
    add_row(OP_RELEASE, 8'd63,  32'hFFFF_FFFF,  EXPECT_ONE,  EV_UP);
    add_row(OP_RELEASE, 8'd10,  32'hFFFF_FFFF,  EXPECT_ONE,  EV_UP);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].now,
                directed_rows[i].check, directed_rows[i].kind);
      pause_sender();
    end

    // Reset settings, with one long event hold-off
    run_phase(50, 32'd2000, 120, 25);

    // Zero delays: every resolved key repeats on each tick
    settle();
    write_reg(CFG_INITIAL_DELAY, 16'd0);
    write_reg(CFG_REPEAT_PERIOD, 16'd0);
    run_phase(30, 32'd1_000_000, 5, -1);

    // Full-scale delays
    settle();
    write_reg(CFG_INITIAL_DELAY, 16'hFFFF);
    write_reg(CFG_REPEAT_PERIOD, 16'hFFFF);
    run_phase(30, 32'h4000_0000, 30000, -1);

    // Repeat off: ticks are dropped
    settle();
    write_reg(CFG_REPEAT_ENABLE, 16'd0);
    run_phase(20, 32'h8000_0000, 50, -1);

    // Repeat back on with short delays
    settle();
    write_reg(CFG_REPEAT_ENABLE, 16'd1);
    write_reg(CFG_INITIAL_DELAY, 16'd40);
    write_reg(CFG_REPEAT_PERIOD, 16'd9);
    run_phase(40, 32'hC000_0000, 25, -1);

    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : key_auto_repeat_engine_test

// ===== filelist.f =====
rtl/kare_pkg.sv
rtl/kare_req_if.sv
rtl/kare_evt_if.sv
rtl/kare_entry_mem.sv
rtl/kare_ctrl.sv
rtl/key_auto_repeat_engine.sv
tb/key_auto_repeat_engine_test.sv
